// ----- hw/rtl/lpm_pkg.sv -----
// Shared types and constants for the longest prefix match lookup core.
// Used by lpm_ctrl, lpm_dp and longest_prefix_match_lookup_core.
package lpm_pkg;

  localparam int SLOT_W            = 5;   // width of a slot number on the ports
  localparam int ADDR_W            = 32;  // IPv4 address and mask width
  localparam int WRITABLE_SLOTS    = 32;  // slots reachable by a 5-bit slot field
  localparam int DEF_TABLE_ENTRIES = 32;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              accept;   // item taken this cycle: clear best, capture key
    logic              wr_en;    // item is a table write
    logic              rd_en;    // read table entry at rd_addr
    logic [SLOT_W-1:0] rd_addr;
    logic              load_out; // move best match into the output register
  } lpm_cmd_t;

endpackage

// ----- hw/rtl/lpm_ctrl.sv -----
// Controller for the LPM lookup core: handshakes, scan counter, output valid.
// Depends on lpm_pkg; drives lpm_dp through an lpm_cmd_t command struct.
module lpm_ctrl import lpm_pkg::*; #(
  parameter int DEPTH = DEF_TABLE_ENTRIES
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     in_action,
  output logic     out_valid,
  input  logic     out_stall,
  output lpm_cmd_t cmd_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t        state_r;
  logic [AW-1:0] idx_r;
  logic          out_valid_r;
  logic          accept;
  logic          out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.wr_en    = accept && (in_action == ACT_WRITE);
    cmd_o.rd_en    = (state_r == ST_SCAN);
    cmd_o.rd_addr  = SLOT_W'(idx_r);
    cmd_o.load_out = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            idx_r   <= '0;
            state_r <= (in_action == ACT_LOOKUP) ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (idx_r == LAST_IDX) begin
            state_r <= ST_DRAIN;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        // last compare lands in the best-match registers
        ST_DRAIN: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && idx_r == LAST_IDX) |=> (state_r == ST_DRAIN))
    else $error("scan did not end after last entry");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.load_out |=> out_valid_r)
    else $error("result loaded without out_valid");

  a_write_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.wr_en |=> (state_r == ST_DONE))
    else $error("write item entered scan");

endmodule

// ----- hw/rtl/lpm_dp.sv -----
// Datapath for the LPM lookup core: route table memory, valid bits,
// one-entry-per-cycle compare stage, best-match and output registers. Uses lpm_pkg.
module lpm_dp import lpm_pkg::*; #(
  parameter int DEPTH = DEF_TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpm_cmd_t          cmd_i,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [ADDR_W-1:0] in_entry_dest,
  input  logic [ADDR_W-1:0] in_entry_mask,
  input  logic              in_entry_valid,
  input  logic [ADDR_W-1:0] in_lookup_key,
  output logic              out_hit,
  output logic [SLOT_W-1:0] out_match_slot,
  output logic [ADDR_W-1:0] out_match_mask
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ADDR_W-1:0] dest_mem [DEPTH];
  logic [ADDR_W-1:0] mask_mem [DEPTH];
  logic [DEPTH-1:0]  valid_r;

  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic              slot_ok;
  logic              wr;

  logic [ADDR_W-1:0] key_r;
  logic [ADDR_W-1:0] dest_q_r;
  logic [ADDR_W-1:0] mask_q_r;
  logic              vld_q_r;
  logic [AW-1:0]     slot_q_r;
  logic              cmp_en_r;

  logic              found_r;
  logic [ADDR_W-1:0] best_mask_r;
  logic [AW-1:0]     best_slot_r;

  logic              out_hit_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [ADDR_W-1:0] out_mask_r;

  logic              match;
  logic              better;

  assign waddr   = in_slot[AW-1:0];
  assign raddr   = cmd_i.rd_addr[AW-1:0];
  assign slot_ok = (32'(in_slot) < 32'(DEPTH));
  assign wr      = cmd_i.wr_en && slot_ok;

  // table memory: one write port (load path), one registered read port (scan)
  always_ff @(posedge clk) begin
    if (wr) begin
      dest_mem[waddr] <= in_entry_dest;
      mask_mem[waddr] <= in_entry_mask;
    end
    if (cmd_i.rd_en) begin
      dest_q_r <= dest_mem[raddr];
      mask_q_r <= mask_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      cmp_en_r <= 1'b0;
    end else begin
      if (wr) begin
        valid_r[waddr] <= in_entry_valid;
      end
      cmp_en_r <= cmd_i.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.rd_en) begin
      vld_q_r  <= valid_r[raddr];
      slot_q_r <= raddr;
    end
  end

  assign match  = cmp_en_r && vld_q_r && (((dest_q_r ^ key_r) & mask_q_r) == '0);
  assign better = !found_r || (mask_q_r > best_mask_r);

  // best-so-far; strict compare keeps the lowest slot on equal masks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd_i.accept) begin
      found_r <= 1'b0;
    end else if (match && better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      key_r       <= in_lookup_key;
      best_mask_r <= '0;
      best_slot_r <= '0;
    end else if (match && better) begin
      best_mask_r <= mask_q_r;
      best_slot_r <= slot_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_hit_r  <= found_r;
      out_slot_r <= SLOT_W'(best_slot_r);
      out_mask_r <= best_mask_r;
    end
  end

  assign out_hit        = out_hit_r;
  assign out_match_slot = out_slot_r;
  assign out_match_mask = out_mask_r;

endmodule

// ----- hw/rtl/longest_prefix_match_lookup_core.sv -----
// IPv4 longest prefix match lookup core.
//
// Input channel (in_valid / in_stall) takes one item at a time. in_action
// selects a table write (slot, entry_dest, entry_mask, entry_valid) or a
// lookup of in_lookup_key. Every item yields exactly one result on the
// output channel (out_valid / out_stall): hit, match_slot, match_mask; a
// write, or a lookup without a match, returns all zeros. Among matching
// valid entries the largest mask wins, the lowest slot on a tie.
// Writes to slots at or above TABLE_ENTRIES are dropped.
//
// Timing: a lookup scans the table one entry per cycle through the single
// read port of the route memory, then goes through a drain state, in which
// the last compare lands in the best-match registers, and a done state,
// which loads the result into the output register; a write goes straight
// to the done state. The next item is accepted once the previous result
// sits in the output register, even if the receiver has not taken it yet;
// a stalled result holds and the core waits with its next result until
// the register frees.
// Reset clears all valid bits at once; no clearing pass is needed.
module longest_prefix_match_lookup_core import lpm_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_action,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [ADDR_W-1:0] in_entry_dest,
  input  logic [ADDR_W-1:0] in_entry_mask,
  input  logic              in_entry_valid,
  input  logic [ADDR_W-1:0] in_lookup_key,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic [SLOT_W-1:0] out_match_slot,
  output logic [ADDR_W-1:0] out_match_mask
);

  // slots above the slot field's range can never be written, so never match
  localparam int DEPTH = (TABLE_ENTRIES < WRITABLE_SLOTS) ? TABLE_ENTRIES : WRITABLE_SLOTS;

  lpm_cmd_t cmd;

  lpm_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd_o     (cmd)
  );

  lpm_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .in_slot        (in_slot),
    .in_entry_dest  (in_entry_dest),
    .in_entry_mask  (in_entry_mask),
    .in_entry_valid (in_entry_valid),
    .in_lookup_key  (in_lookup_key),
    .out_hit        (out_hit),
    .out_match_slot (out_match_slot),
    .out_match_mask (out_match_mask)
  );

endmodule

// ----- test/lpm_route_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the longest prefix match lookup core: mirrors the route table,
// predicts one result per accepted item and compares it with the result port.
// Depends on lpm_pkg.
module lpm_route_checker import lpm_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_action,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [ADDR_W-1:0] in_entry_dest,
  input  logic [ADDR_W-1:0] in_entry_mask,
  input  logic              in_entry_valid,
  input  logic [ADDR_W-1:0] in_lookup_key,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_hit,
  input  logic [SLOT_W-1:0] out_match_slot,
  input  logic [ADDR_W-1:0] out_match_mask,
  output int                mismatch_count,
  output int                outstanding,
  output int                lookups_seen,
  output int                hits_seen
);

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] mask;
  } route_match_t;

  logic [ADDR_W-1:0] route_dest  [TABLE_ENTRIES];
  logic [ADDR_W-1:0] route_mask  [TABLE_ENTRIES];
  logic              route_valid [TABLE_ENTRIES];
  route_match_t      pending_matches [$];

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("@%0t: %s", $time, msg);
    end
  endtask

  // Largest mask among valid matching entries; strict compare keeps the lowest slot on a tie.
  function automatic route_match_t longest_match(logic [ADDR_W-1:0] key);
    route_match_t best = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (route_valid[i] && ((route_dest[i] ^ key) & route_mask[i]) == '0 &&
          (!best.hit || route_mask[i] > best.mask)) begin
        best.hit  = 1'b1;
        best.slot = i[SLOT_W-1:0];
        best.mask = route_mask[i];
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin : monitor
    route_match_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        route_valid[i] = 1'b0;
      end
      pending_matches.delete();
      outstanding <= 0;
    end else begin
      // results first, so a result can never be matched to the item taken at the same edge
      if (out_valid && !out_stall) begin
        if (pending_matches.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: hit %0b slot %0d mask %h",
                                    out_hit, out_match_slot, out_match_mask));
        end else begin
          want = pending_matches.pop_front();
          if (out_hit !== want.hit)
            report_mismatch($sformatf("hit: got %b, expected %b", out_hit, want.hit));
          if (out_match_slot !== want.slot)
            report_mismatch($sformatf("match_slot: got %0d, expected %0d",
                                      out_match_slot, want.slot));
          if (out_match_mask !== want.mask)
            report_mismatch($sformatf("match_mask: got %h, expected %h",
                                      out_match_mask, want.mask));
        end
      end
      if (in_valid && !in_stall) begin
        want = '0;
        if (in_action == ACT_WRITE) begin
          if (in_slot < TABLE_ENTRIES) begin
            route_dest[in_slot]  = in_entry_dest;
            route_mask[in_slot]  = in_entry_mask;
            route_valid[in_slot] = in_entry_valid;
          end
        end else begin
          want = longest_match(in_lookup_key);
          lookups_seen++;
          if (want.hit) hits_seen++;
        end
        pending_matches.push_back(want);
      end
      outstanding <= pending_matches.size();
    end
  end

endmodule

// ----- test/longest_prefix_match_lookup_core_test.sv -----
`timescale 1ns / 1ps
// Top of the longest prefix match testbench: drives route writes and lookups with
// random gaps and result stalls, and prints the verdict. Depends on lpm_pkg,
// longest_prefix_match_lookup_core and lpm_route_checker.
module longest_prefix_match_lookup_core_test import lpm_pkg::*;;

  localparam int RANDOM_ITEMS = 1000;
  localparam int STUCK_LIMIT  = 2000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_action;
  logic [SLOT_W-1:0] in_slot;
  logic [ADDR_W-1:0] in_entry_dest;
  logic [ADDR_W-1:0] in_entry_mask;
  logic              in_entry_valid;
  logic [ADDR_W-1:0] in_lookup_key;
  logic              out_valid;
  logic              out_stall;
  logic              out_hit;
  logic [SLOT_W-1:0] out_match_slot;
  logic [ADDR_W-1:0] out_match_mask;

  int mismatch_count;
  int outstanding;
  int lookups_seen;
  int hits_seen;
  int items_sent;
  bit quiet;

  // what the table holds, used to aim lookup keys at stored routes
  logic [ADDR_W-1:0] stored_dest [WRITABLE_SLOTS];
  logic [ADDR_W-1:0] stored_mask [WRITABLE_SLOTS];
  logic [ADDR_W-1:0] prefix_base [4];

  longest_prefix_match_lookup_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_slot        (in_slot),
    .in_entry_dest  (in_entry_dest),
    .in_entry_mask  (in_entry_mask),
    .in_entry_valid (in_entry_valid),
    .in_lookup_key  (in_lookup_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_match_slot (out_match_slot),
    .out_match_mask (out_match_mask)
  );

  lpm_route_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_slot        (in_slot),
    .in_entry_dest  (in_entry_dest),
    .in_entry_mask  (in_entry_mask),
    .in_entry_valid (in_entry_valid),
    .in_lookup_key  (in_lookup_key),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_match_slot (out_match_slot),
    .out_match_mask (out_match_mask),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding),
    .lookups_seen   (lookups_seen),
    .hits_seen      (hits_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      out_stall <= !quiet && ($urandom_range(99) < 22);
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("no handshake for %0d cycles", STUCK_LIMIT);
    $display("longest_prefix_match_lookup_core_test failed");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] prefix_mask(int len);
    return (len == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - len));
  endfunction

  task automatic maybe_idle();
    if (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 48)) @(posedge clk);
    end
  endtask

  // holds the item until the edge at which it is taken
  task automatic send_item(logic act, logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] dest,
                           logic [ADDR_W-1:0] mask, logic valid, logic [ADDR_W-1:0] key);
    maybe_idle();
    in_valid       <= 1'b1;
    in_action      <= act;
    in_slot        <= slot;
    in_entry_dest  <= dest;
    in_entry_mask  <= mask;
    in_entry_valid <= valid;
    in_lookup_key  <= key;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (act == ACT_WRITE) begin
      stored_dest[slot] = dest;
      stored_mask[slot] = mask;
    end
  endtask

  task automatic write_route(logic [SLOT_W-1:0] slot, logic [ADDR_W-1:0] dest,
                             logic [ADDR_W-1:0] mask, logic valid);
    send_item(ACT_WRITE, slot, dest, mask, valid, $urandom);
  endtask

  task automatic look_up(logic [ADDR_W-1:0] key);
    send_item(ACT_LOOKUP, SLOT_W'($urandom), $urandom, $urandom, 1'($urandom), key);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] key;
    int pick;
    int src;

    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_action      <= ACT_WRITE;
    in_slot        <= '0;
    in_entry_dest  <= '0;
    in_entry_mask  <= '0;
    in_entry_valid <= 1'b0;
    in_lookup_key  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every slot, all invalid, so no lookup ever scans an unwritten entry
    for (int s = 0; s < WRITABLE_SLOTS; s++) begin
      write_route(s[SLOT_W-1:0], $urandom, $urandom, 1'b0);
    end

    look_up(32'h0000_0000);                              // empty table
    write_route(5'd0, 32'h0000_0000, 32'h0000_0000, 1'b1); // default route /0
    look_up(32'hFFFF_FFFF);
    write_route(5'd31, 32'h8000_0000, prefix_mask(1), 1'b1);
    look_up(32'h8000_0001);
    write_route(5'd5, 32'hC0A8_0100, prefix_mask(24), 1'b1);
    write_route(5'd3, 32'hC0A8_0100, prefix_mask(24), 1'b1); // tie, lower slot wins
    look_up(32'hC0A8_01FE);
    write_route(5'd10, 32'hC0A8_0101, prefix_mask(32), 1'b1);
    look_up(32'hC0A8_0101);
    write_route(5'd3, 32'hC0A8_0100, prefix_mask(24), 1'b0); // withdraw, keeps dest/mask
    look_up(32'hC0A8_01FE);
    write_route(5'd7, 32'h0A00_0B00, 32'hFF00_FF00, 1'b1);   // non-contiguous mask
    look_up(32'h0A55_0B77);
    write_route(5'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    look_up(32'hFFFF_FFFF);
    write_route(5'd0, 32'h0000_0000, 32'h0000_0000, 1'b0);
    look_up(32'h1234_5678);
    look_up(32'h7FFF_FFFF);
    drain();

    prefix_base[0] = 32'h0A00_0000;
    prefix_base[1] = 32'hC0A8_0000;
    prefix_base[2] = $urandom;
    prefix_base[3] = $urandom;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n >= 300 && n < 450);
      if (n == 600) drain();
      if ($urandom_range(99) < 35) begin
        slot = SLOT_W'($urandom_range(WRITABLE_SLOTS - 1));
        pick = $urandom_range(99);
        if (pick < 10) begin
          // duplicate of another route to provoke ties
          src  = $urandom_range(WRITABLE_SLOTS - 1);
          dest = stored_dest[src];
          mask = stored_mask[src];
        end else begin
          mask = (pick < 18) ? $urandom : prefix_mask($urandom_range(32));
          if ($urandom_range(3) == 0) dest = $urandom;
          else dest = prefix_base[$urandom_range(3)] ^
                      ($urandom & ~prefix_mask($urandom_range(8, 24)));
        end
        write_route(slot, dest, mask, $urandom_range(99) < 85);
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          src = $urandom_range(WRITABLE_SLOTS - 1);
          key = stored_dest[src] ^ ($urandom & ~stored_mask[src]);
          if ($urandom_range(9) == 0) key = key ^ (32'h1 << $urandom_range(31)); // near miss
        end else if (pick < 80) begin
          key = prefix_base[$urandom_range(3)] ^ ($urandom & 32'h0000_FFFF);
        end else begin
          key = $urandom;
        end
        look_up(key);
      end
    end
    quiet = 1'b0;

    drain();
    repeat (50) @(posedge clk);
    $display("sent %0d items: %0d lookups with %0d hits, the rest route writes,", items_sent,
             lookups_seen, hits_seen);
    $display("under random sender gaps and result stalls, with stall-free and drained phases");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("longest_prefix_match_lookup_core_test passed");
    end else begin
      $display("longest_prefix_match_lookup_core_test failed");
    end
    $finish;
  end

endmodule
